>>> sv/tcpm_pkg.sv
// shared types and constants for the tone curve pixel mapper
// used by tcpm_div, tcpm_datapath, tcpm_ctrl and the top level
package tcpm_pkg;

  localparam int CurveEntries = 256;
  localparam int IdxW         = $clog2(CurveEntries);
  localparam int PixW         = 8;
  localparam int LevW         = 9;
  localparam int DivW         = 9;
  localparam int DivCntW      = $clog2(DivW + 1);

  localparam logic [IdxW-1:0] IdxLast = IdxW'(CurveEntries - 1);
  localparam logic [PixW-1:0] PixMax  = '1;

  typedef enum logic [1:0] {
    KindWrite   = 2'd0,
    KindStretch = 2'd1,
    KindPoster  = 2'd2,
    KindPixel   = 2'd3
  } kind_e;

  localparam logic [1:0] ChanBlue  = 2'd0;
  localparam logic [1:0] ChanGreen = 2'd1;
  localparam logic [1:0] ChanRed   = 2'd2;

  typedef enum logic [1:0] {
    SweepClear   = 2'd0,
    SweepStretch = 2'd1,
    SweepPoster  = 2'd2
  } sweep_e;

  typedef enum logic [1:0] {
    DivStretch = 2'd0,
    DivPostA   = 2'd1,
    DivPostB   = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic            wr_item;
    logic            rd_item;
    logic            cap_item;
    logic            div_start;
    div_sel_e        div_sel;
    logic            sweep_en;
    sweep_e          sweep_mode;
    logic [IdxW-1:0] sweep_idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_block;
  } sts_t;

endpackage

>>> sv/tcpm_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on tcpm_pkg
module tcpm_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tcpm_pkg::DivW-1:0] dividend_i,
  input  logic [tcpm_pkg::DivW-1:0] divisor_i,
  output logic                     done_o,
  output logic [tcpm_pkg::DivW-1:0] quo_o,
  output logic [tcpm_pkg::DivW-1:0] rem_o
);
  import tcpm_pkg::*;

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic               done_q;
  logic [DivW-1:0]    rem_q;
  logic [DivW-1:0]    quo_q;
  logic [DivW-1:0]    dvs_q;
  logic [DivW:0]      trial;
  logic [DivW:0]      diff;
  logic               ge;

  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(DivW);
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> sv/tcpm_datapath.sv
// curve memories, stretch and posterize curve generators, pixel lookup and output register
// depends on tcpm_pkg and tcpm_div
module tcpm_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcpm_pkg::cmd_t             cmd_i,
  output tcpm_pkg::sts_t             sts_o,
  input  logic [1:0]                 channel_i,
  input  logic [tcpm_pkg::IdxW-1:0]  entry_index_i,
  input  logic [tcpm_pkg::PixW-1:0]  entry_value_i,
  input  logic [tcpm_pkg::PixW-1:0]  low_bound_i,
  input  logic [tcpm_pkg::PixW-1:0]  high_bound_i,
  input  logic [tcpm_pkg::LevW-1:0]  levels_i,
  input  logic [tcpm_pkg::IdxW-1:0]  blue_i,
  input  logic [tcpm_pkg::IdxW-1:0]  green_i,
  input  logic [tcpm_pkg::IdxW-1:0]  red_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [tcpm_pkg::PixW-1:0]  out_blue_o,
  output logic [tcpm_pkg::PixW-1:0]  out_green_o,
  output logic [tcpm_pkg::PixW-1:0]  out_red_o
);
  import tcpm_pkg::*;

  logic [PixW-1:0] blue_mem  [CurveEntries];
  logic [PixW-1:0] green_mem [CurveEntries];
  logic [PixW-1:0] red_mem   [CurveEntries];

  logic [PixW-1:0] lo_q;
  logic [PixW-1:0] hi_q;
  logic [LevW-1:0] lv_q;
  logic [LevW-1:0] lv_clamp;

  logic            div_done;
  logic [DivW-1:0] div_quo;
  logic [DivW-1:0] div_rem;
  logic [DivW-1:0] dividend;
  logic [DivW-1:0] divisor;

  // stretch tracker
  logic [DivW-1:0] qs_q, rs_q, sq_q, sr_q;
  logic [PixW-1:0] span;
  logic [DivW-1:0] s_sum, sq_next, sr_next;
  logic            s_wrap;

  // posterize trackers
  logic [DivW-1:0] qa_q, qb_q, b_q, v_q;
  logic [DivW:0]   ra_q, rb_q, brem_q, vrem_q;
  logic [DivW:0]   two_l, d2, br_sum, vr_sum, b_init_sum;
  logic [DivW-1:0] b_next, v_inc, v_sel;
  logic [DivW:0]   brem_next, vrem_next;
  logic            br_wrap, vr_wrap, hit;

  logic [IdxW-1:0] idx;
  logic [PixW-1:0] sweep_val;
  logic [IdxW-1:0] waddr;
  logic [PixW-1:0] wdata;
  logic            we_blue, we_green, we_red;
  logic            out_valid_q;
  logic [PixW-1:0] out_blue_q, out_green_q, out_red_q;

  always_comb begin
    priority if (levels_i < LevW'(2)) lv_clamp = LevW'(2);
    else if (levels_i > LevW'(CurveEntries)) lv_clamp = LevW'(CurveEntries);
    else lv_clamp = levels_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      lo_q <= low_bound_i;
      hi_q <= high_bound_i;
      lv_q <= lv_clamp;
    end
  end

  assign span  = hi_q - lo_q;
  assign two_l = {lv_q, 1'b0};
  assign d2    = {lv_q - LevW'(1), 1'b0};

  always_comb begin
    dividend = (cmd_i.div_sel == DivStretch) ? DivW'(255) : DivW'(CurveEntries);
    unique case (cmd_i.div_sel)
      DivStretch: divisor = {1'b0, span};
      DivPostA:   divisor = lv_q;
      DivPostB:   divisor = lv_q - LevW'(1);
      default:    divisor = lv_q;
    endcase
  end

  tcpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign idx = cmd_i.sweep_idx;

  always_comb begin
    s_sum   = sr_q + rs_q;
    s_wrap  = s_sum >= {1'b0, span};
    sq_next = sq_q + qs_q + DivW'(s_wrap);
    sr_next = s_wrap ? s_sum - {1'b0, span} : s_sum;

    hit       = {1'b0, idx} >= b_q;
    br_sum    = brem_q + ra_q;
    br_wrap   = br_sum >= two_l;
    b_next    = b_q + qa_q + DivW'(br_wrap);
    brem_next = br_wrap ? br_sum - two_l : br_sum;
    vr_sum    = vrem_q + rb_q;
    vr_wrap   = vr_sum >= d2;
    v_inc     = v_q + qb_q + DivW'(vr_wrap);
    vrem_next = vr_wrap ? vr_sum - d2 : vr_sum;
    v_sel     = hit ? v_inc : v_q;

    b_init_sum = {div_rem, 1'b0} + {1'b0, lv_q};

    unique case (cmd_i.sweep_mode)
      SweepClear: sweep_val = '0;
      SweepStretch: begin
        priority if (idx <= lo_q) sweep_val = '0;
        else if (idx >= hi_q) sweep_val = PixMax;
        else sweep_val = sq_next[PixW-1:0];
      end
      SweepPoster: sweep_val = (v_sel > DivW'(PixMax)) ? PixMax : v_sel[PixW-1:0];
      default: sweep_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      unique case (cmd_i.div_sel)
        DivStretch: begin
          qs_q <= div_quo;
          rs_q <= div_rem;
          sq_q <= '0;
          sr_q <= '0;
        end
        DivPostA: begin
          qa_q <= div_quo;
          ra_q <= {div_rem, 1'b0};
          if (b_init_sum >= two_l) begin
            b_q    <= div_quo + DivW'(1);
            brem_q <= b_init_sum - two_l;
          end else begin
            b_q    <= div_quo;
            brem_q <= b_init_sum;
          end
        end
        DivPostB: begin
          qb_q   <= div_quo;
          rb_q   <= {div_rem, 1'b0};
          v_q    <= '0;
          vrem_q <= {1'b0, d2[DivW:1]};
        end
        default: begin
          qs_q <= div_quo;
        end
      endcase
    end else if (cmd_i.sweep_en) begin
      if (cmd_i.sweep_mode == SweepStretch && idx > lo_q) begin
        sq_q <= sq_next;
        sr_q <= sr_next;
      end
      if (cmd_i.sweep_mode == SweepPoster && hit) begin
        b_q    <= b_next;
        brem_q <= brem_next;
        v_q    <= v_inc;
        vrem_q <= vrem_next;
      end
    end
  end

  always_comb begin
    waddr    = cmd_i.sweep_en ? idx : entry_index_i;
    wdata    = cmd_i.sweep_en ? sweep_val : entry_value_i;
    we_blue  = cmd_i.sweep_en || (cmd_i.wr_item && channel_i == ChanBlue);
    we_green = cmd_i.sweep_en || (cmd_i.wr_item && channel_i == ChanGreen);
    we_red   = cmd_i.sweep_en || (cmd_i.wr_item && channel_i == ChanRed);
  end

  always_ff @(posedge clk_i) begin
    if (we_blue) blue_mem[waddr] <= wdata;
    if (we_green) green_mem[waddr] <= wdata;
    if (we_red) red_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_item) begin
      out_blue_q  <= blue_mem[blue_i];
      out_green_q <= green_mem[green_i];
      out_red_q   <= red_mem[red_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rd_item) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.out_block = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_blue_o      = out_blue_q;
  assign out_green_o     = out_green_q;
  assign out_red_o       = out_red_q;

endmodule

>>> sv/tcpm_ctrl.sv
// controller state machine: reset clear sweep, item dispatch, divide and rebuild sweeps
// depends on tcpm_pkg
module tcpm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     kind_i,
  input  tcpm_pkg::sts_t sts_i,
  output logic           in_stall_o,
  output tcpm_pkg::cmd_t cmd_o
);
  import tcpm_pkg::*;

  typedef enum logic [6:0] {
    StClear  = 7'b0000001,
    StIdle   = 7'b0000010,
    StDivS   = 7'b0000100,
    StSweepS = 7'b0001000,
    StDivPa  = 7'b0010000,
    StDivPb  = 7'b0100000,
    StSweepP = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            start_q, start_d;
  logic            idle;
  logic            accept;
  logic            last;

  assign idle   = state_q == StIdle;
  assign accept = in_valid_i && idle && !sts_i.out_block;
  assign last   = idx_q == IdxLast;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    start_d = 1'b0;
    unique case (state_q)
      StClear, StSweepS, StSweepP: begin
        idx_d = idx_q + IdxW'(1);
        if (last) state_d = StIdle;
      end
      StIdle: begin
        if (accept && kind_i == KindStretch) begin
          state_d = StDivS;
          start_d = 1'b1;
        end else if (accept && kind_i == KindPoster) begin
          state_d = StDivPa;
          start_d = 1'b1;
        end
      end
      StDivS: begin
        if (sts_i.div_done) state_d = StSweepS;
      end
      StDivPa: begin
        if (sts_i.div_done) begin
          state_d = StDivPb;
          start_d = 1'b1;
        end
      end
      StDivPb: begin
        if (sts_i.div_done) state_d = StSweepP;
      end
      default: begin
        state_d = StIdle;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      idx_q   <= '0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      start_q <= start_d;
    end
  end

  always_comb begin
    cmd_o.wr_item   = accept && kind_i == KindWrite;
    cmd_o.rd_item   = accept && kind_i == KindPixel;
    cmd_o.cap_item  = accept && (kind_i == KindStretch || kind_i == KindPoster);
    cmd_o.div_start = start_q;
    unique case (state_q)
      StDivPa: cmd_o.div_sel = DivPostA;
      StDivPb: cmd_o.div_sel = DivPostB;
      default: cmd_o.div_sel = DivStretch;
    endcase
    cmd_o.sweep_en = state_q == StClear || state_q == StSweepS || state_q == StSweepP;
    unique case (state_q)
      StSweepS: cmd_o.sweep_mode = SweepStretch;
      StSweepP: cmd_o.sweep_mode = SweepPoster;
      default:  cmd_o.sweep_mode = SweepClear;
    endcase
    cmd_o.sweep_idx = idx_q;
  end

  assign in_stall_o = !idle || sts_i.out_block;

endmodule

>>> sv/tone_curve_pixel_mapper_unit.sv
// Tone curve pixel mapper: three 256 x 8 curves (blue, green, red) with entry writes, stretch
// and posterize rebuilds and per-pixel lookup. Write and pixel transactions are taken one per
// cycle while the output register is not held; a pixel result is registered in the cycle
// after it is accepted and holds while out_stall_i is high. After reset the block clears all
// curves in a sweep over all 256 entries during which in_stall_o stays high. A stretch rebuild
// keeps the input stalled through one 9-step divide, then one curve entry per cycle over 256
// entries; a posterize rebuild through two 9-step divides, then the 256-entry sweep. The single
// write port of each curve memory sets the one-entry-per-cycle sweep rate.
// depends on tcpm_pkg, tcpm_ctrl, tcpm_datapath
module tone_curve_pixel_mapper_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 kind_i,
  input  logic [1:0]                 channel_i,
  input  logic [tcpm_pkg::IdxW-1:0]  entry_index_i,
  input  logic [tcpm_pkg::PixW-1:0]  entry_value_i,
  input  logic [tcpm_pkg::PixW-1:0]  low_bound_i,
  input  logic [tcpm_pkg::PixW-1:0]  high_bound_i,
  input  logic [tcpm_pkg::LevW-1:0]  levels_i,
  input  logic [tcpm_pkg::IdxW-1:0]  blue_i,
  input  logic [tcpm_pkg::IdxW-1:0]  green_i,
  input  logic [tcpm_pkg::IdxW-1:0]  red_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tcpm_pkg::PixW-1:0]  out_blue_o,
  output logic [tcpm_pkg::PixW-1:0]  out_green_o,
  output logic [tcpm_pkg::PixW-1:0]  out_red_o
);
  import tcpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  tcpm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .channel_i     (channel_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .low_bound_i   (low_bound_i),
    .high_bound_i  (high_bound_i),
    .levels_i      (levels_i),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_blue_o    (out_blue_o),
    .out_green_o   (out_green_o),
    .out_red_o     (out_red_o)
  );

  // a result only follows an accepted pixel transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && kind_i == KindPixel))
    else $error("result without pixel transaction");

  // no transaction accepted while a curve sweep is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep_en |-> in_stall_o)
    else $error("input open during sweep");

  // never accept while the output register is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(out_valid_o && out_stall_i))
    else $error("accept with blocked output");

endmodule

>>> dv/tone_curve_pixel_mapper_unit_test.sv
`timescale 1ns / 100ps
// testbench for tone_curve_pixel_mapper_unit: directed table then random traffic
// checked against a local curve model; depends on tcpm_pkg and the unit itself
module tone_curve_pixel_mapper_unit_test;
  import tcpm_pkg::*;

  localparam logic [1:0] ChanNone = 2'd3;
  localparam int PlanRows   = 25;
  localparam int ItemTarget = 800;
  localparam int HoldAfter  = 200;
  localparam int HoldCycles = 300;
  localparam int DrainWait  = 300;
  localparam int QuietLimit = 4000;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] chan;
    logic [7:0] idx;
    logic [7:0] val;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [8:0] lev;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    bit         typed;
    logic [7:0] xb;
    logic [7:0] xg;
    logic [7:0] xr;
  } txn_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  // kind, chan, idx, val, lo, hi, lev, b, g, r, typed, expected b g r
  txn_t plan [PlanRows] = '{
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0,   0, 128, 255, 1,   0,   0,   0},
    '{KindWrite,   ChanBlue,  0, 255,   0,   0,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindWrite,   ChanGreen, 255, 170, 0,   0,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindWrite,   ChanRed,   128, 85,  0,   0,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindWrite,   ChanNone,  0,   1,   0,   0,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindWrite,   ChanBlue,  255, 0,   0,   0,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0,   0, 255, 128, 1, 255, 170,  85},
    '{KindStretch, ChanBlue,  0,   0,   0, 255,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0,   0, 255, 100, 1,   0, 255, 100},
    '{KindStretch, ChanBlue,  0,   0, 200,  50,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0, 200, 201,   0, 1,   0, 255,   0},
    '{KindStretch, ChanBlue,  0,   0, 255, 255,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0, 255,   0, 128, 1,   0,   0,   0},
    '{KindStretch, ChanBlue,  0,   0,  10,  20,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0,  15,  10,  20, 1, 127,   0, 255},
    '{KindPoster,  ChanBlue,  0,   0,   0,   0,   2,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0, 127, 128, 255, 1,   0, 255, 255},
    '{KindPoster,  ChanBlue,  0,   0,   0,   0,   0,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0, 127, 128,   0, 1,   0, 255,   0},
    '{KindPoster,  ChanBlue,  0,   0,   0,   0, 511,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0,   0,   1, 255, 1,   0,   1, 255},
    '{KindPoster,  ChanBlue,  0,   0,   0,   0, 256,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0,   2, 128, 254, 0,   0,   0,   0},
    '{KindPoster,  ChanBlue,  0,   0,   0,   0,   3,   0,   0,   0, 0,   0,   0,   0},
    '{KindPixel,   ChanBlue,  0,   0,   0,   0,   0,  85,  86, 170, 0,   0,   0,   0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] kind_i;
  logic [1:0] channel_i;
  logic [7:0] entry_index_i;
  logic [7:0] entry_value_i;
  logic [7:0] low_bound_i;
  logic [7:0] high_bound_i;
  logic [8:0] levels_i;
  logic [7:0] blue_i;
  logic [7:0] green_i;
  logic [7:0] red_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_blue_o;
  logic [7:0] out_green_o;
  logic [7:0] out_red_o;

  logic [7:0] curve_b [CurveEntries];
  logic [7:0] curve_g [CurveEntries];
  logic [7:0] curve_r [CurveEntries];
  logic [7:0] last_wr_idx;
  rgb_t       pending_pixels [$];

  int errors;
  int checked;
  int taken;
  int useful;
  int n_write;
  int n_stretch;
  int n_poster;
  int n_pixel;
  int quiet;
  bit held;

  tone_curve_pixel_mapper_unit uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void rebuild_stretch(logic [7:0] lo, logic [7:0] hi);
    int v;
    int l;
    int h;
    l = int'(lo);
    h = int'(hi);
    for (int i = 0; i < CurveEntries; i++) begin
      if (i <= l) v = 0;
      else if (i >= h) v = 255;
      else v = (255 * (i - l)) / (h - l);
      curve_b[IdxW'(i)] = v[7:0];
      curve_g[IdxW'(i)] = v[7:0];
      curve_r[IdxW'(i)] = v[7:0];
    end
  endfunction

  function automatic void rebuild_poster(logic [8:0] lev);
    int lv;
    int k;
    int count;
    int v;
    lv = int'(lev);
    if (lv < 2) lv = 2;
    if (lv > CurveEntries) lv = CurveEntries;
    k = 1;
    count = 0;
    for (int i = 0; i < CurveEntries; i++) begin
      while (k <= lv && (2 * k * CurveEntries + lv) / (2 * lv) <= i) begin
        count++;
        k++;
      end
      v = (2 * count * CurveEntries + lv - 1) / (2 * (lv - 1));
      if (v > 255) v = 255;
      curve_b[IdxW'(i)] = v[7:0];
      curve_g[IdxW'(i)] = v[7:0];
      curve_r[IdxW'(i)] = v[7:0];
    end
  endfunction

  // update the curve model with one accepted transaction
  function automatic void absorb(txn_t t);
    rgb_t px;
    case (t.kind)
      KindWrite: begin
        n_write++;
        last_wr_idx = t.idx;
        case (t.chan)
          ChanBlue:  curve_b[t.idx] = t.val;
          ChanGreen: curve_g[t.idx] = t.val;
          ChanRed:   curve_r[t.idx] = t.val;
          default: ;
        endcase
      end
      KindStretch: begin
        n_stretch++;
        rebuild_stretch(t.lo, t.hi);
      end
      KindPoster: begin
        n_poster++;
        rebuild_poster(t.lev);
      end
      default: begin
        n_pixel++;
        if (t.typed) px = '{t.xb, t.xg, t.xr};
        else px = '{curve_b[t.b], curve_g[t.g], curve_r[t.r]};
        pending_pixels.push_back(px);
      end
    endcase
    if (!(t.kind == KindWrite && t.chan == ChanNone)) useful++;
  endfunction

  function automatic txn_t random_item();
    txn_t t;
    int pick;
    t = '0;
    t.idx = 8'($urandom_range(0, 255));
    t.val = 8'($urandom_range(0, 255));
    t.b = 8'($urandom_range(0, 255));
    t.g = 8'($urandom_range(0, 255));
    t.r = 8'($urandom_range(0, 255));
    t.chan = ($urandom_range(0, 19) == 0) ? ChanNone : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 0) begin
      t.lo = 8'($urandom_range(0, 254));
      t.hi = 8'($urandom_range(int'(t.lo) + 1, 255));
    end else begin
      t.lo = 8'($urandom_range(0, 255));
      t.hi = 8'($urandom_range(0, 255));
    end
    t.lev = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                        : 9'($urandom_range(2, 256));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      t.kind = KindPixel;
      if ($urandom_range(0, 2) == 0) begin
        t.b = last_wr_idx;
        t.g = last_wr_idx;
        t.r = last_wr_idx;
      end
    end else if (pick < 87) t.kind = KindWrite;
    else if (pick < 94) t.kind = KindStretch;
    else t.kind = KindPoster;
    return t;
  endfunction

  task automatic drive_item(txn_t t);
    in_valid_i    <= 1'b1;
    kind_i        <= t.kind;
    channel_i     <= t.chan;
    entry_index_i <= t.idx;
    entry_value_i <= t.val;
    low_bound_i   <= t.lo;
    high_bound_i  <= t.hi;
    levels_i      <= t.lev;
    blue_i        <= t.b;
    green_i       <= t.g;
    red_i         <= t.r;
    do @(posedge clk_i); while (in_stall_o);
    taken++;
    absorb(t);
  endtask

  initial begin : sender
    txn_t t;
    int burst;
    int gap;
    errors = 0;
    checked = 0;
    taken = 0;
    useful = 0;
    n_write = 0;
    n_stretch = 0;
    n_poster = 0;
    n_pixel = 0;
    last_wr_idx = '0;
    for (int i = 0; i < CurveEntries; i++) begin
      curve_b[IdxW'(i)] = '0;
      curve_g[IdxW'(i)] = '0;
      curve_r[IdxW'(i)] = '0;
    end
    in_valid_i    <= 1'b0;
    kind_i        <= KindWrite;
    channel_i     <= ChanBlue;
    entry_index_i <= '0;
    entry_value_i <= '0;
    low_bound_i   <= '0;
    high_bound_i  <= '0;
    levels_i      <= '0;
    blue_i        <= '0;
    green_i       <= '0;
    red_i         <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (plan[n]) drive_item(plan[n]);
    while (useful < ItemTarget) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        t = random_item();
        drive_item(t);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    $display("covered %0d entry writes, %0d stretch and %0d posterize rebuilds, %0d pixels",
             n_write, n_stretch, n_poster, n_pixel);
    $display("%0d pixel results checked, %0d errors", checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off to back the block up
  initial begin : receiver
    int mode;
    int left;
    mode = 0;
    left = 0;
    held = 1'b0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && taken >= HoldAfter) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(8, 64);
        end
        left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("unexpected result b=%0d g=%0d r=%0d",
                             out_blue_o, out_green_o, out_red_o));
      end else begin
        want = pending_pixels.pop_front();
        checked++;
        if (out_blue_o !== want.b || out_green_o !== want.g || out_red_o !== want.r)
          note_error($sformatf("pixel %0d expected b=%0d g=%0d r=%0d got b=%0d g=%0d r=%0d",
                               checked, want.b, want.g, want.r,
                               out_blue_o, out_green_o, out_red_o));
      end
    end
  end

  // watchdog on cycles without any transaction
  initial quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("timeout after %0d idle cycles", quiet);
      $display("status: fail");
      $finish;
    end
  end

endmodule
